### src/assert_macros.svh
// Assertion macros shared by the lock table RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked at every clock edge outside reset.
`define FLFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define FLFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FLFT_ASSERT(lbl, prop, msg)
`define FLFT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### src/flft_pkg.sv
// Package for the five-level lock table: sizes, codes and shared types.
// Depends on nothing.
package flft_pkg;

  localparam int RESOURCES = 16;
  localparam int HOLDERS   = 8;

  localparam int LV_W    = 3;
  localparam int ROW_W   = HOLDERS * LV_W;
  localparam int RES_AW  = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int HOLD_AW = $clog2(HOLDERS);

  // Widths that hold the field values and the largest allowed counts.
  localparam int RES_EXT_W  = 9;
  localparam int HOLD_EXT_W = 6;

  localparam logic [LV_W-1:0] LV_NONE      = 3'd0;
  localparam logic [LV_W-1:0] LV_SHARED    = 3'd1;
  localparam logic [LV_W-1:0] LV_RESERVED  = 3'd2;
  localparam logic [LV_W-1:0] LV_PENDING   = 3'd3;
  localparam logic [LV_W-1:0] LV_EXCLUSIVE = 3'd4;

  typedef enum logic [1:0] {
    OP_LOCK      = 2'd0,
    OP_UNLOCK    = 2'd1,
    OP_RSV_QUERY = 2'd2,
    OP_LVL_QUERY = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    op_t                 opcode;
    logic [RES_AW-1:0]   res;
    logic [HOLD_AW-1:0]  hold;
    logic [LV_W-1:0]     want;
    logic                in_range;
  } req_t;

  typedef struct packed {
    logic            row_we;
    logic            status;
    logic [LV_W-1:0] answer;
  } eval_t;

endpackage

### src/flft_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module flft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/flft_eval.sv
// Decision logic for one request against one resource row of holder levels.
// Depends on flft_pkg.
module flft_eval (
  input  flft_pkg::req_t                  req,
  input  logic [flft_pkg::ROW_W-1:0]      row,
  output logic [flft_pkg::ROW_W-1:0]      row_new,
  output flft_pkg::eval_t                 res
);
  import flft_pkg::*;

  always_comb begin
    logic [LV_W-1:0] own;
    logic [LV_W-1:0] thr;
    logic [LV_W-1:0] lv;
    logic            busy;
    logic            any_rsv;
    own     = row[req.hold*LV_W +: LV_W];
    busy    = 1'b0;
    any_rsv = 1'b0;

    unique case (req.want) inside
      LV_SHARED:               thr = LV_PENDING;
      LV_RESERVED, LV_PENDING: thr = LV_RESERVED;
      default:                 thr = LV_SHARED;
    endcase

    // Blocking check skips the requester; the reserved query counts everyone.
    for (int h = 0; h < HOLDERS; h++) begin
      lv = row[h*LV_W +: LV_W];
      if ((HOLD_AW'(h) != req.hold) && (lv >= thr)) begin
        busy = 1'b1;
      end
      if (lv >= LV_RESERVED) begin
        any_rsv = 1'b1;
      end
    end

    row_new = row;
    row_new[req.hold*LV_W +: LV_W] = req.want;
    res = '0;

    if (req.in_range) begin
      unique case (req.opcode)
        OP_LOCK: begin
          if (req.want > own) begin
            res.status = busy;
            res.row_we = !busy;
          end
        end
        OP_UNLOCK:    res.row_we = 1'b1;
        OP_RSV_QUERY: res.answer = any_rsv ? LV_W'(1) : LV_W'(0);
        OP_LVL_QUERY: res.answer = own;
        default:      res = '0;
      endcase
    end
  end

endmodule

### src/five_level_file_lock_table_unit.sv
// Five-level lock table: one word in, one result word out per request.
// The input word and its row are registered when the word is taken; the result
// is registered once any earlier result has been claimed. No new word is taken
// until the row of the last one has been read, decided and, if changed, written back.
// Reset (synchronous, rst_n low) clears the per-row valid flags, so every
// lock reads as none at once; no clearing pass is needed.
`include "assert_macros.svh"

module five_level_file_lock_table_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [3:0] in_resource_id,
  input  logic [2:0] in_holder_id,
  input  logic [2:0] in_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_status,
  output logic [2:0] out_answer
);
  import flft_pkg::*;

  // The state is one row per resource, each row holding the 3-bit levels of
  // all holders. The memory has no reset, so a flip-flop per row marks rows
  // written since reset; an unmarked row reads as all zero.
  state_t                state_r, state_nxt;
  req_t                  req_r, req_nxt;
  logic [RESOURCES-1:0]  row_valid_r;
  logic                  rd_valid_r;
  logic                  out_valid_r;
  logic                  out_status_r;
  logic [LV_W-1:0]       out_answer_r;

  logic                  accept;
  logic                  exec;
  logic                  out_load;
  logic                  ram_we;
  logic [ROW_W-1:0]      ram_rdata;
  logic [ROW_W-1:0]      row_cur;
  logic [ROW_W-1:0]      row_new;
  eval_t                 ev;
  logic [RES_EXT_W-1:0]  res_ext;
  logic [HOLD_EXT_W-1:0] hold_ext;

  // Incoming word: widen the ids for the range check and clamp the level
  // so that anything above exclusive counts as exclusive.
  always_comb begin
    res_ext          = RES_EXT_W'(in_resource_id);
    hold_ext         = HOLD_EXT_W'(in_holder_id);
    req_nxt.opcode   = op_t'(in_opcode);
    req_nxt.res      = res_ext[RES_AW-1:0];
    req_nxt.hold     = hold_ext[HOLD_AW-1:0];
    req_nxt.want     = (in_level > LV_EXCLUSIVE) ? LV_EXCLUSIVE : in_level;
    req_nxt.in_range = (res_ext < RES_EXT_W'(RESOURCES)) &&
                       (hold_ext < HOLD_EXT_W'(HOLDERS));
  end

  // Next-state logic. A word is read in IDLE and resolved in EXEC; EXEC
  // waits only while the previous result still sits unclaimed.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready = 1'b0;
    exec     = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_EXEC: exec     = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  assign accept   = in_valid && in_ready;
  assign out_load = exec && (!out_valid_r || out_ready);
  // The write lands on the same edge the result is loaded, before the next
  // word can issue its read, so no forwarding path is needed.
  assign ram_we   = out_load && ev.row_we;
  assign row_cur  = rd_valid_r ? ram_rdata : '0;

  flft_ram #(
    .WIDTH (ROW_W),
    .DEPTH (RESOURCES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req_r.res),
    .wdata (row_new),
    .re    (accept),
    .raddr (req_nxt.res),
    .rdata (ram_rdata)
  );

  flft_eval u_eval (
    .req     (req_r),
    .row     (row_cur),
    .row_new (row_new),
    .res     (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        row_valid_r[req_r.res] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= req_nxt;
      rd_valid_r <= row_valid_r[req_nxt.res];
    end
    if (out_load) begin
      out_status_r <= ev.status;
      out_answer_r <= ev.answer;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_answer = out_answer_r;

  `FLFT_ASSERT(a_out_from_exec, $rose(out_valid_r) |-> ($past(state_r) == ST_EXEC), "result without execute")
  `FLFT_ASSERT(a_busy_only_lock, (exec && ev.status) |-> (req_r.opcode == OP_LOCK), "busy on non-lock")
  `FLFT_ASSERT(a_no_write_on_busy, (exec && ev.status) |-> !ev.row_we, "refused lock writes row")
  `FLFT_ASSERT_NEXT(a_row_marked, ram_we, row_valid_r[$past(req_r.res)], "written row not marked")
  `FLFT_ASSERT_NEXT(a_accept_exec, accept, (state_r == ST_EXEC), "accepted word not executed")

endmodule
